// ----- rtl/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg
// Constants and types shared by the binomial-mod-prime unit.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int VAL_W    = 30;
    localparam int K_W      = 12;
    localparam int RED_W    = 32;
    localparam int CNT_W    = 5;
    localparam int KCMP_W   = 17;

    localparam logic [VAL_W-1:0]  PRIME    = 30'd998244353;
    localparam logic [RED_W-1:0]  PRIME_W  = 32'd998244353;
    localparam logic [RED_W-1:0]  PRIME_X2 = 32'd1996488706;
    localparam logic [VAL_W-1:0]  INV_EXP  = 30'd998244351;
    localparam logic [CNT_W-1:0]  LAST_BIT = 5'd29;
    localparam logic [KCMP_W-1:0] MAX_K    = 17'd4096;

    typedef logic [VAL_W-1:0] val_t;

    typedef struct packed {
        logic start;
        val_t a;
        val_t b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        val_t prod;
    } mul_rsp_t;

endpackage

// ----- rtl/bmp_in_if.sv -----
// ----------------------------------------------------------------------------
// bmp_in_if
// Request channel: upper and lower binomial arguments.
// ----------------------------------------------------------------------------
interface bmp_in_if;
    logic        valid;
    logic        ready;
    logic [29:0] top;
    logic [11:0] choose;

    modport source (output valid, output top, output choose, input ready);
    modport sink   (input valid, input top, input choose, output ready);
endinterface

// ----- rtl/bmp_out_if.sv -----
// ----------------------------------------------------------------------------
// bmp_out_if
// Result channel: binomial coefficient modulo the prime.
// ----------------------------------------------------------------------------
interface bmp_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] binom;

    modport source (output valid, output binom, input ready);
    modport sink   (input valid, input binom, output ready);
endinterface

// ----- rtl/bmp_mod_mul.sv -----
// ----------------------------------------------------------------------------
// bmp_mod_mul
// Bit-serial modular multiplier: one bit of b per cycle, MSB first,
// Horner accumulation with reduction below the prime each step.
// ----------------------------------------------------------------------------
module bmp_mod_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  bmp_pkg::mul_req_t req,
    output bmp_pkg::mul_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [bmp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    bmp_pkg::val_t             a_reg, a_next;
    bmp_pkg::val_t             b_reg, b_next;
    bmp_pkg::val_t             acc_reg, acc_next;

    logic [bmp_pkg::RED_W-1:0] sum;
    logic [bmp_pkg::RED_W-1:0] red;

    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0}
            + (b_reg[bmp_pkg::VAL_W-1] ? {2'b00, a_reg} : '0);
        if (sum >= bmp_pkg::PRIME_X2)
        begin
            red = sum - bmp_pkg::PRIME_X2;
        end
        else if (sum >= bmp_pkg::PRIME_W)
        begin
            red = sum - bmp_pkg::PRIME_W;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = bmp_pkg::LAST_BIT;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = red[bmp_pkg::VAL_W-1:0];
            b_next   = {b_reg[bmp_pkg::VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ----- rtl/binomial_mod_prime_unit.sv -----
// ----------------------------------------------------------------------------
// binomial_mod_prime_unit
// C(top, choose) modulo 998244353 on one shared bit-serial multiplier.
//
// req carries top and choose; rsp returns binom, one item per request.
// Items are handled one at a time: req.ready is high while the sequencer
// is idle, and a new item may be taken while the previous result still
// waits in the output register.
// Each modular multiplication runs on the bit-serial unit as an issue,
// 30 bit steps and a completion. An item costs two multiplications per
// factor plus 57 for the Fermat inversion and one final product.
// choose > top, or choose at or beyond the bound, skips the arithmetic
// and gives 0. choose = 0 skips the factor loop and gives 1.
// Reset returns the sequencer to idle and empties the output register;
// nothing else needs clearing.
// When rsp.ready is low the finished result is held; a further finished
// result waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module binomial_mod_prime_unit (
    input  logic             clk,
    input  logic             rst_n,
    bmp_in_if.sink           req,
    bmp_out_if.source        rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NUM  = 3'd1;
    localparam logic [2:0] S_DEN  = 3'd2;
    localparam logic [2:0] S_POWM = 3'd3;
    localparam logic [2:0] S_POWS = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic                      issued_reg, issued_next;
    logic                      ovalid_reg, ovalid_next;
    logic [bmp_pkg::K_W-1:0]   i_reg, i_next;
    logic [bmp_pkg::K_W-1:0]   k_reg, k_next;
    logic [bmp_pkg::CNT_W-1:0] bit_reg, bit_next;
    bmp_pkg::val_t             fac_reg, fac_next;
    bmp_pkg::val_t             num_reg, num_next;
    bmp_pkg::val_t             den_reg, den_next;
    bmp_pkg::val_t             acc_reg, acc_next;
    bmp_pkg::val_t             sq_reg, sq_next;
    bmp_pkg::val_t             exp_reg, exp_next;
    bmp_pkg::val_t             res_reg, res_next;
    bmp_pkg::val_t             binom_reg, binom_next;

    bmp_pkg::mul_req_t         mreq;
    bmp_pkg::mul_rsp_t         mrsp;

    logic [bmp_pkg::K_W:0]     i_inc;
    bmp_pkg::val_t             top_mod;
    logic                      refuse;

    bmp_mod_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign i_inc   = {1'b0, i_reg} + 1'b1;
    assign top_mod = (req.top >= bmp_pkg::PRIME) ? req.top - bmp_pkg::PRIME : req.top;
    assign refuse  = ({5'b0, req.choose} >= bmp_pkg::MAX_K)
                   || ({18'b0, req.choose} > req.top);

    always_comb
    begin
        mreq.start = 1'b0;
        mreq.a     = num_reg;
        mreq.b     = fac_reg;
        case (state_reg)
            S_NUM:
            begin
                mreq.a = num_reg;
                mreq.b = fac_reg;
            end
            S_DEN:
            begin
                mreq.a = den_reg;
                mreq.b = {{(bmp_pkg::VAL_W-bmp_pkg::K_W-1){1'b0}}, i_inc};
            end
            S_POWM:
            begin
                mreq.a = acc_reg;
                mreq.b = sq_reg;
            end
            S_POWS:
            begin
                mreq.a = sq_reg;
                mreq.b = sq_reg;
            end
            S_FIN:
            begin
                mreq.a = num_reg;
                mreq.b = acc_reg;
            end
            default:
            begin
                mreq.a = num_reg;
                mreq.b = fac_reg;
            end
        endcase
        if (!issued_reg && (state_reg inside {S_NUM, S_DEN, S_POWS, S_FIN}
            || (state_reg == S_POWM && exp_reg[0])))
        begin
            mreq.start = 1'b1;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.binom = binom_reg;

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        ovalid_next = ovalid_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        bit_next    = bit_reg;
        fac_next    = fac_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        res_next    = res_reg;
        binom_next  = binom_reg;

        if (rsp.valid && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (mreq.start)
        begin
            issued_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    i_next   = '0;
                    k_next   = req.choose;
                    bit_next = '0;
                    fac_next = top_mod;
                    num_next = 30'd1;
                    den_next = 30'd1;
                    acc_next = 30'd1;
                    sq_next  = 30'd1;
                    exp_next = bmp_pkg::INV_EXP;
                    res_next = '0;
                    if (refuse)
                    begin
                        state_next = S_DONE;
                    end
                    else if (req.choose == '0)
                    begin
                        state_next = S_POWM;
                    end
                    else
                    begin
                        state_next = S_NUM;
                    end
                end
            end
            S_NUM:
            begin
                if (mrsp.done)
                begin
                    issued_next = 1'b0;
                    num_next    = mrsp.prod;
                    fac_next    = (fac_reg == '0) ? bmp_pkg::PRIME - 1'b1 : fac_reg - 1'b1;
                    state_next  = S_DEN;
                end
            end
            S_DEN:
            begin
                if (mrsp.done)
                begin
                    issued_next = 1'b0;
                    den_next    = mrsp.prod;
                    i_next      = i_inc[bmp_pkg::K_W-1:0];
                    if (i_inc == {1'b0, k_reg})
                    begin
                        sq_next    = mrsp.prod;
                        state_next = S_POWM;
                    end
                    else
                    begin
                        state_next = S_NUM;
                    end
                end
            end
            S_POWM:
            begin
                if (!exp_reg[0] || mrsp.done)
                begin
                    issued_next = 1'b0;
                    if (exp_reg[0])
                    begin
                        acc_next = mrsp.prod;
                    end
                    state_next = (bit_reg == bmp_pkg::LAST_BIT) ? S_FIN : S_POWS;
                end
            end
            S_POWS:
            begin
                if (mrsp.done)
                begin
                    issued_next = 1'b0;
                    sq_next     = mrsp.prod;
                    exp_next    = {1'b0, exp_reg[bmp_pkg::VAL_W-1:1]};
                    bit_next    = bit_reg + 1'b1;
                    state_next  = S_POWM;
                end
            end
            S_FIN:
            begin
                if (mrsp.done)
                begin
                    issued_next = 1'b0;
                    res_next    = mrsp.prod;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    binom_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next  = S_IDLE;
                issued_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            ovalid_reg <= ovalid_next;
            i_reg      <= i_next;
            bit_reg    <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        fac_reg   <= fac_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        exp_reg   <= exp_next;
        res_reg   <= res_next;
        binom_reg <= binom_next;
    end

endmodule
